// ===== rtl/core/qvr_pkg.sv =====
// Shared types, widths and codes of the quaternion vector rotator.
`timescale 1ns / 1ps

package qvr_pkg;

  // Fixed widths of the datapath
  localparam int NORM_W     = 64;  // squared length, normalized
  localparam int ROOT_W     = NORM_W / 2;
  localparam int H_W        = 5;   // half of the normalizing shift
  localparam int QUAT_W     = 16;
  localparam int ROT_W      = 16;
  localparam int STAT_W     = 2;
  localparam int T_W        = 19;  // first Hamilton product, after rounding
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd16384;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_SAT  = 2'd2
  } qvr_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_X = 2'd0,
    REG_QUAT_Y = 2'd1,
    REG_QUAT_Z = 2'd2,
    REG_QUAT_W = 2'd3
  } qvr_reg_e;

  typedef struct packed {
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
    logic signed [QUAT_W-1:0] w;
  } qvr_quat_t;

  // Per-item flags that ride along the pipeline
  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
  } qvr_side_t;

endpackage

// ===== rtl/core/qvr_vec_if.sv =====
// Input vector stream: valid/ready plus the three vector components.
`timescale 1ns / 1ps

interface qvr_vec_if #(
  parameter int IN_WIDTH = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] vec_x;
  logic signed [IN_WIDTH-1:0] vec_y;
  logic signed [IN_WIDTH-1:0] vec_z;

  modport source (output valid, vec_x, vec_y, vec_z, input ready);
  modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

// ===== rtl/core/qvr_rot_if.sv =====
// Result stream: valid/ready plus the rotated vector and its status.
`timescale 1ns / 1ps

interface qvr_rot_if;
  logic                              valid;
  logic                              ready;
  logic signed [qvr_pkg::ROT_W-1:0]  rot_x;
  logic signed [qvr_pkg::ROT_W-1:0]  rot_y;
  logic signed [qvr_pkg::ROT_W-1:0]  rot_z;
  logic        [qvr_pkg::STAT_W-1:0] status;

  modport source (output valid, rot_x, rot_y, rot_z, status, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, status, output ready);
endinterface

// ===== rtl/core/qvr_norm.sv =====
// Magnitudes, squared length and even normalizing shift of the input vector.
`timescale 1ns / 1ps

module qvr_norm #(
  parameter int IN_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [IN_WIDTH-1:0]    vec_x_i,
  input  logic signed [IN_WIDTH-1:0]    vec_y_i,
  input  logic signed [IN_WIDTH-1:0]    vec_z_i,
  output logic                          valid_o,
  output logic [qvr_pkg::NORM_W-1:0]    x_o,
  output logic [qvr_pkg::H_W-1:0]       h_o,
  output logic [3*IN_WIDTH-1:0]         mag_o,
  output qvr_pkg::qvr_side_t            side_o
);

  localparam int SQ_W = 2 * IN_WIDTH;
  localparam int NSH  = $clog2(qvr_pkg::NORM_W) - 1;  // shifts of 32, 16, 8, 4, 2
  localparam int NST  = NSH + 2;

  logic signed [IN_WIDTH-1:0] vin [3];
  logic [IN_WIDTH-1:0]        mag_d [3];
  logic [2:0]                 neg_d;
  logic [SQ_W-1:0]            l2_d;

  logic [NST-1:0]             v_q;
  logic [SQ_W-1:0]            sq_q [3];
  logic [3*IN_WIDTH-1:0]      mag_q [NST];
  qvr_pkg::qvr_side_t         side_q [NST];
  logic [qvr_pkg::NORM_W-1:0] xs_q [NSH+1];
  logic [qvr_pkg::H_W-1:0]    h_q [NSH+1];
  logic [qvr_pkg::NORM_W-1:0] xs_d [NSH];
  logic [qvr_pkg::H_W-1:0]    h_d [NSH];

  assign vin[0] = vec_x_i;
  assign vin[1] = vec_y_i;
  assign vin[2] = vec_z_i;

  // Sign and magnitude; the most negative value maps to 2^(IN_WIDTH-1)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = vin[i][IN_WIDTH-1];
      mag_d[i] = neg_d[i] ? IN_WIDTH'(-vin[i]) : IN_WIDTH'(vin[i]);
    end
  end

  assign l2_d = sq_q[0] + sq_q[1] + sq_q[2];

  // One binary step of the leading-zero shift per stage, even amounts only
  always_comb begin
    int sh;
    for (int j = 0; j < NSH; j++) begin
      sh = (qvr_pkg::NORM_W / 2) >> j;
      if ((xs_q[j] >> (qvr_pkg::NORM_W - sh)) == '0) begin
        xs_d[j] = xs_q[j] << sh;
        h_d[j]  = h_q[j] + qvr_pkg::H_W'(sh >> 1);
      end else begin
        xs_d[j] = xs_q[j];
        h_d[j]  = h_q[j];
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SQ_W'(mag_d[i]) * SQ_W'(mag_d[i]);
      end
      mag_q[0]  <= {mag_d[2], mag_d[1], mag_d[0]};
      side_q[0] <= '{zero: 1'b0, neg: neg_d};

      xs_q[0]   <= qvr_pkg::NORM_W'(l2_d);
      h_q[0]    <= '0;
      mag_q[1]  <= mag_q[0];
      side_q[1] <= '{zero: (l2_d == '0), neg: side_q[0].neg};

      for (int j = 0; j < NSH; j++) begin
        xs_q[j+1]   <= xs_d[j];
        h_q[j+1]    <= h_d[j];
        mag_q[j+2]  <= mag_q[j+1];
        side_q[j+2] <= side_q[j+1];
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign x_o     = xs_q[NSH];
  assign h_o     = h_q[NSH];
  assign mag_o   = mag_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

// ===== rtl/core/qvr_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module qvr_sqrt #(
  parameter int PASS_W = 57
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [qvr_pkg::NORM_W-1:0] x_i,
  input  logic [PASS_W-1:0]          pass_i,
  output logic                       valid_o,
  output logic [qvr_pkg::ROOT_W-1:0] root_o,
  output logic [PASS_W-1:0]          pass_o
);

  localparam int NST  = qvr_pkg::ROOT_W;
  localparam int REM_W = qvr_pkg::ROOT_W + 2;
  localparam int TR_W  = REM_W + 2;

  logic [NST-1:0]             v_q;
  logic [qvr_pkg::NORM_W-1:0] x_q [NST];
  logic [REM_W-1:0]           rem_q [NST];
  logic [qvr_pkg::ROOT_W-1:0] root_q [NST];
  logic [PASS_W-1:0]          pass_q [NST];

  logic [qvr_pkg::NORM_W-1:0] x_s [NST];
  logic [REM_W-1:0]           rem_s [NST];
  logic [qvr_pkg::ROOT_W-1:0] root_s [NST];
  logic [qvr_pkg::NORM_W-1:0] x_d [NST];
  logic [REM_W-1:0]           rem_d [NST];
  logic [qvr_pkg::ROOT_W-1:0] root_d [NST];

  // Stage inputs: the first stage starts from zero root and remainder
  always_comb begin
    x_s[0]    = x_i;
    rem_s[0]  = '0;
    root_s[0] = '0;
    for (int i = 1; i < NST; i++) begin
      x_s[i]    = x_q[i-1];
      rem_s[i]  = rem_q[i-1];
      root_s[i] = root_q[i-1];
    end
  end

  // Digit-by-digit step: bring down two bits, try 4*root+1
  always_comb begin
    logic [TR_W-1:0] trial;
    logic [TR_W-1:0] tcmp;
    for (int i = 0; i < NST; i++) begin
      trial  = {rem_s[i], x_s[i][qvr_pkg::NORM_W-1 -: 2]};
      tcmp   = TR_W'({root_s[i], 2'b01});
      x_d[i] = x_s[i] << 2;
      if (trial >= tcmp) begin
        rem_d[i]  = REM_W'(trial - tcmp);
        root_d[i] = {root_s[i][qvr_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d[i]  = REM_W'(trial);
        root_d[i] = {root_s[i][qvr_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pass_q[0] <= pass_i;
      for (int i = 0; i < NST; i++) begin
        x_q[i]    <= x_d[i];
        rem_q[i]  <= rem_d[i];
        root_q[i] <= root_d[i];
        if (i > 0) begin
          pass_q[i] <= pass_q[i-1];
        end
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign root_o  = root_q[NST-1];
  assign pass_o  = pass_q[NST-1];

endmodule

// ===== rtl/core/qvr_div.sv =====
// Three-lane restoring divider: rounded unit components mag * 2^(F+h) / root.
`timescale 1ns / 1ps

module qvr_div #(
  parameter int FRAC_BITS = 14,
  parameter int IN_WIDTH  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [qvr_pkg::ROOT_W-1:0]     root_i,
  input  logic [3*IN_WIDTH-1:0]          mag_i,
  input  logic [qvr_pkg::H_W-1:0]        h_i,
  input  qvr_pkg::qvr_side_t             side_i,
  output logic                           valid_o,
  output logic signed [FRAC_BITS+1:0]    n_x_o,
  output logic signed [FRAC_BITS+1:0]    n_y_o,
  output logic signed [FRAC_BITS+1:0]    n_z_o,
  output logic                           zero_o
);

  localparam int DW  = qvr_pkg::ROOT_W + FRAC_BITS + 1;
  localparam int QW  = FRAC_BITS + 1;
  localparam int NW  = FRAC_BITS + 2;
  localparam int NQ  = QW;
  localparam int NST = NQ + 2;

  logic [NST-1:0]             v_q;
  logic [DW-1:0]              rem_q [NQ+1][3];
  logic [QW-1:0]              quo_q [NQ+1][3];
  logic [qvr_pkg::ROOT_W-1:0] s_q [NQ+1];
  qvr_pkg::qvr_side_t         side_q [NQ+1];
  logic signed [NW-1:0]       n_q [3];
  logic                       zero_q;

  logic [DW-1:0]              dvd_d [3];
  logic [DW-1:0]              rem_d [NQ][3];
  logic [QW-1:0]              quo_d [NQ][3];
  logic signed [NW-1:0]       n_d [3];

  // Dividend with half the divisor added for round-to-nearest
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dvd_d[l] = ((DW'(mag_i[l*IN_WIDTH +: IN_WIDTH]) << FRAC_BITS) << h_i)
               + DW'(root_i >> 1);
    end
  end

  // One quotient bit per stage, most significant first
  always_comb begin
    logic [DW-1:0] dv;
    for (int k = 0; k < NQ; k++) begin
      dv = DW'(s_q[k]) << (NQ - 1 - k);
      for (int l = 0; l < 3; l++) begin
        if (rem_q[k][l] >= dv) begin
          rem_d[k][l] = rem_q[k][l] - dv;
          quo_d[k][l] = {quo_q[k][l][QW-2:0], 1'b1};
        end else begin
          rem_d[k][l] = rem_q[k][l];
          quo_d[k][l] = {quo_q[k][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  // Restore the sign
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      n_d[l] = side_q[NQ].neg[l] ? -signed'({1'b0, quo_q[NQ][l]})
                                 :  signed'({1'b0, quo_q[NQ][l]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0]    <= root_i;
      side_q[0] <= side_i;
      for (int l = 0; l < 3; l++) begin
        rem_q[0][l] <= dvd_d[l];
        quo_q[0][l] <= '0;
      end
      for (int k = 0; k < NQ; k++) begin
        s_q[k+1]    <= s_q[k];
        side_q[k+1] <= side_q[k];
        for (int l = 0; l < 3; l++) begin
          rem_q[k+1][l] <= rem_d[k][l];
          quo_q[k+1][l] <= quo_d[k][l];
        end
      end
      for (int l = 0; l < 3; l++) begin
        n_q[l] <= n_d[l];
      end
      zero_q <= side_q[NQ].zero;
    end
  end

  assign valid_o = v_q[NST-1];
  assign n_x_o   = n_q[0];
  assign n_y_o   = n_q[1];
  assign n_z_o   = n_q[2];
  assign zero_o  = zero_q;

endmodule

// ===== rtl/core/qvr_rot.sv =====
// Two Hamilton products q*n*conj(q), rounding, saturation and output skid.
`timescale 1ns / 1ps

module qvr_rot #(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [FRAC_BITS+1:0] n_x_i,
  input  logic signed [FRAC_BITS+1:0] n_y_i,
  input  logic signed [FRAC_BITS+1:0] n_z_i,
  input  logic                        zero_i,
  input  qvr_pkg::qvr_quat_t          quat_i,
  output logic                        en_o,
  qvr_rot_if.source                   rot_o
);

  localparam int NW   = FRAC_BITS + 2;
  localparam int P_W  = NW + qvr_pkg::QUAT_W;
  localparam int S1_W = P_W + 2;
  localparam int P2_W = qvr_pkg::QUAT_W + qvr_pkg::T_W;
  localparam int S2_W = P2_W + 2;

  localparam logic signed [S1_W-1:0] RND1  = S1_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [S2_W-1:0] RND2  = S2_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [S2_W-1:0] R_MAX = 32767;
  localparam logic signed [S2_W-1:0] R_MIN = -32768;

  logic                                en;
  logic                                va_q, vb_q, vc_q;
  logic signed [P_W-1:0]               pa_q [12];
  logic signed [P_W-1:0]               pa_d [12];
  logic signed [qvr_pkg::T_W-1:0]      t_q [4];
  logic signed [qvr_pkg::T_W-1:0]      t_d [4];
  logic signed [P2_W-1:0]              pb_q [12];
  logic signed [P2_W-1:0]              pb_d [12];
  logic                                za_q, zb_q, zc_q;

  logic signed [qvr_pkg::ROT_W-1:0]    res_rot [3];
  qvr_pkg::qvr_status_e                res_stat;

  logic                                out_v_q, skid_v_q;
  logic signed [qvr_pkg::ROT_W-1:0]    out_rot_q [3];
  logic signed [qvr_pkg::ROT_W-1:0]    skid_rot_q [3];
  qvr_pkg::qvr_status_e                out_stat_q, skid_stat_q;
  logic                                take, push, load_out, load_skid, move_skid;

  // The whole pipeline moves while the skid slot is free
  assign en   = !skid_v_q;
  assign en_o = en;

  // First product t = n * conj(q), partial products
  always_comb begin
    pa_d[0]  = n_x_i * quat_i.w;
    pa_d[1]  = n_y_i * quat_i.z;
    pa_d[2]  = n_z_i * quat_i.y;
    pa_d[3]  = n_y_i * quat_i.w;
    pa_d[4]  = n_z_i * quat_i.x;
    pa_d[5]  = n_x_i * quat_i.z;
    pa_d[6]  = n_z_i * quat_i.w;
    pa_d[7]  = n_x_i * quat_i.y;
    pa_d[8]  = n_y_i * quat_i.x;
    pa_d[9]  = n_x_i * quat_i.x;
    pa_d[10] = n_y_i * quat_i.y;
    pa_d[11] = n_z_i * quat_i.z;
  end

  // Sums and round half-up
  always_comb begin
    logic signed [S1_W-1:0] sum [4];
    sum[0] = pa_q[0] - pa_q[1] + pa_q[2];
    sum[1] = pa_q[3] - pa_q[4] + pa_q[5];
    sum[2] = pa_q[6] - pa_q[7] + pa_q[8];
    sum[3] = pa_q[9] + pa_q[10] + pa_q[11];
    for (int i = 0; i < 4; i++) begin
      t_d[i] = qvr_pkg::T_W'((sum[i] + RND1) >>> FRAC_BITS);
    end
  end

  // Second product r = q * t; t holds x, y, z, w in that order
  always_comb begin
    pb_d[0]  = quat_i.w * t_q[0];
    pb_d[1]  = quat_i.x * t_q[3];
    pb_d[2]  = quat_i.y * t_q[2];
    pb_d[3]  = quat_i.z * t_q[1];
    pb_d[4]  = quat_i.w * t_q[1];
    pb_d[5]  = quat_i.y * t_q[3];
    pb_d[6]  = quat_i.z * t_q[0];
    pb_d[7]  = quat_i.x * t_q[2];
    pb_d[8]  = quat_i.w * t_q[2];
    pb_d[9]  = quat_i.z * t_q[3];
    pb_d[10] = quat_i.x * t_q[1];
    pb_d[11] = quat_i.y * t_q[0];
  end

  // Final sums, rounding, clamp and status
  always_comb begin
    logic signed [S2_W-1:0] sum;
    logic signed [S2_W-1:0] r;
    logic                   sat;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum = pb_q[4*i] + pb_q[4*i+1] + pb_q[4*i+2] - pb_q[4*i+3];
      r   = (sum + RND2) >>> FRAC_BITS;
      if (r > R_MAX) begin
        res_rot[i] = qvr_pkg::ROT_W'(R_MAX);
        sat        = 1'b1;
      end else if (r < R_MIN) begin
        res_rot[i] = qvr_pkg::ROT_W'(R_MIN);
        sat        = 1'b1;
      end else begin
        res_rot[i] = qvr_pkg::ROT_W'(r);
      end
      if (zc_q) begin
        res_rot[i] = '0;
      end
    end
    if (zc_q) begin
      res_stat = qvr_pkg::STAT_ZERO;
    end else if (sat) begin
      res_stat = qvr_pkg::STAT_SAT;
    end else begin
      res_stat = qvr_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q <= pa_d;
      t_q  <= t_d;
      pb_q <= pb_d;
      za_q <= zero_i;
      zb_q <= za_q;
      zc_q <= zb_q;
    end
  end

  // Output register with one skid slot behind it
  assign take      = out_v_q && rot_o.ready;
  assign push      = en && vc_q;
  assign load_out  = push && (!out_v_q || take);
  assign load_skid = push && out_v_q && !take;
  assign move_skid = skid_v_q && take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (load_out || move_skid) begin
        out_v_q <= 1'b1;
      end else if (take) begin
        out_v_q <= 1'b0;
      end
      if (load_skid) begin
        skid_v_q <= 1'b1;
      end else if (move_skid) begin
        skid_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_skid) begin
      out_rot_q  <= skid_rot_q;
      out_stat_q <= skid_stat_q;
    end else if (load_out) begin
      out_rot_q  <= res_rot;
      out_stat_q <= res_stat;
    end
    if (load_skid) begin
      skid_rot_q  <= res_rot;
      skid_stat_q <= res_stat;
    end
  end

  assign rot_o.valid  = out_v_q;
  assign rot_o.rot_x  = out_rot_q[0];
  assign rot_o.rot_y  = out_rot_q[1];
  assign rot_o.rot_z  = out_rot_q[2];
  assign rot_o.status = out_stat_q;

endmodule

// ===== rtl/core/quaternion_vector_rotate.sv =====
// Top level of the quaternion vector rotator.
`timescale 1ns / 1ps

// Rotates each incoming 3-vector by the quaternion held in the four quat
// registers (Q2.14, reset to identity): the vector is scaled to unit length
// with an exact square root and a rounded divide, then q*n*conj(q) is formed
// and x, y, z leave in Q2.14, clamped to 16 bits. status is 0 for a good
// result, 1 for a zero-length input (output zero) and 2 when a component
// clamped. One vector is accepted every clock cycle while input ready is
// high; the pipeline runs through the normalizer, the 32-stage square root,
// the FRAC_BITS + 1 quotient stages of the divider and the two Hamilton
// products. A result that is not taken parks in the output register and one
// skid slot; input ready drops only once both are occupied. Write the
// quaternion only while no vector is in flight.

module quaternion_vector_rotate #(
  parameter int FRAC_BITS = 14,
  parameter int IN_WIDTH  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [qvr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  qvr_vec_if.sink                        vec_i,
  qvr_rot_if.source                      rot_o
);

  localparam int PASS_W = 3 * IN_WIDTH + $bits(qvr_pkg::qvr_side_t) + qvr_pkg::H_W;

  qvr_pkg::qvr_quat_t         quat_q;
  logic                       en;

  logic                       norm_valid;
  logic [qvr_pkg::NORM_W-1:0] norm_x;
  logic [qvr_pkg::H_W-1:0]    norm_h;
  logic [3*IN_WIDTH-1:0]      norm_mag;
  qvr_pkg::qvr_side_t         norm_side;

  logic                       sq_valid;
  logic [qvr_pkg::ROOT_W-1:0] sq_root;
  logic [PASS_W-1:0]          sq_pass;
  logic [3*IN_WIDTH-1:0]      sq_mag;
  qvr_pkg::qvr_side_t         sq_side;
  logic [qvr_pkg::H_W-1:0]    sq_h;

  logic                       dv_valid;
  logic signed [FRAC_BITS+1:0] dv_n_x, dv_n_y, dv_n_z;
  logic                       dv_zero;

  // Quaternion registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q <= '{x: '0, y: '0, z: '0, w: qvr_pkg::QUAT_ONE};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qvr_pkg::REG_QUAT_X: quat_q.x <= signed'(cfg_data_i);
        qvr_pkg::REG_QUAT_Y: quat_q.y <= signed'(cfg_data_i);
        qvr_pkg::REG_QUAT_Z: quat_q.z <= signed'(cfg_data_i);
        qvr_pkg::REG_QUAT_W: quat_q.w <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign vec_i.ready = en;

  qvr_norm #(
    .IN_WIDTH (IN_WIDTH)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vec_i.valid),
    .vec_x_i (vec_i.vec_x),
    .vec_y_i (vec_i.vec_y),
    .vec_z_i (vec_i.vec_z),
    .valid_o (norm_valid),
    .x_o     (norm_x),
    .h_o     (norm_h),
    .mag_o   (norm_mag),
    .side_o  (norm_side)
  );

  qvr_sqrt #(
    .PASS_W (PASS_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (norm_valid),
    .x_i     (norm_x),
    .pass_i  ({norm_mag, norm_side, norm_h}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .pass_o  (sq_pass)
  );

  assign {sq_mag, sq_side, sq_h} = sq_pass;

  qvr_div #(
    .FRAC_BITS (FRAC_BITS),
    .IN_WIDTH  (IN_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .root_i  (sq_root),
    .mag_i   (sq_mag),
    .h_i     (sq_h),
    .side_i  (sq_side),
    .valid_o (dv_valid),
    .n_x_o   (dv_n_x),
    .n_y_o   (dv_n_y),
    .n_z_o   (dv_n_z),
    .zero_o  (dv_zero)
  );

  qvr_rot #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_valid),
    .n_x_i   (dv_n_x),
    .n_y_i   (dv_n_y),
    .n_z_i   (dv_n_z),
    .zero_i  (dv_zero),
    .quat_i  (quat_q),
    .en_o    (en),
    .rot_o   (rot_o)
  );

endmodule

// ===== rtl/core/qvr_checker.sv =====
// Port-level checks of the quaternion vector rotator, bound to the top level.
`timescale 1ns / 1ps

module qvr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [qvr_pkg::ROT_W-1:0]  rot_x_i,
  input logic signed [qvr_pkg::ROT_W-1:0]  rot_y_i,
  input logic signed [qvr_pkg::ROT_W-1:0]  rot_z_i,
  input logic        [qvr_pkg::STAT_W-1:0] status_i
);

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // Input back-pressure only follows an output stall
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input ready low without an output stall");

  // Zero-length input gives a zero vector
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == qvr_pkg::STAT_ZERO |->
      rot_x_i == '0 && rot_y_i == '0 && rot_z_i == '0)
    else $error("zero-length status with nonzero vector");

  // Saturation status means some component sits on a rail
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == qvr_pkg::STAT_SAT |->
      rot_x_i == 16'sh7fff || rot_x_i == 16'sh8000 ||
      rot_y_i == 16'sh7fff || rot_y_i == 16'sh8000 ||
      rot_z_i == 16'sh7fff || rot_z_i == 16'sh8000)
    else $error("saturation status with no clamped component");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (vec_i.ready),
  .out_valid_i (rot_o.valid),
  .out_ready_i (rot_o.ready),
  .rot_x_i     (rot_o.rot_x),
  .rot_y_i     (rot_o.rot_y),
  .rot_z_i     (rot_o.rot_z),
  .status_i    (rot_o.status)
);
